// ===== hdl/min_max_contrast_stretch_macros.svh =====
// ---------------------------------------------------------------------------
// Contrast stretch assertion macros
// Clocked assertion helpers for the contrast stretch RTL.
// ---------------------------------------------------------------------------
`ifndef MIN_MAX_CONTRAST_STRETCH_MACROS_SVH
`define MIN_MAX_CONTRAST_STRETCH_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define MMCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, bound to the block's own clock and reset names.
`define MMCS_ASSERT_CLK(label, prop, msg) \
  `MMCS_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/mmcs_pkg.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch package
// Shared constants, codes and types of the contrast stretch block.
// ---------------------------------------------------------------------------
package mmcs_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int KIND_BITS      = 2;

  typedef enum logic [1:0] {
    ACT_RESET   = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_MAP     = 2'd2
  } action_e;

  // What the back end has to do with a queued map pixel
  typedef enum logic [KIND_BITS-1:0] {
    JOB_PASS = 2'd0,
    JOB_ZERO = 2'd1,
    JOB_FULL = 2'd2,
    JOB_DIV  = 2'd3
  } job_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/mmcs_in_if.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch input channel
// Valid/ready channel carrying an action code and a pixel.
// ---------------------------------------------------------------------------
interface mmcs_in_if #(
  parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

// ===== hdl/mmcs_out_if.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch output channel
// Valid/ready channel carrying a stretched pixel.
// ---------------------------------------------------------------------------
interface mmcs_out_if #(
  parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== hdl/min_max_contrast_stretch.sv =====
// Sequence: a divided map pixel is queued, popped, run through one divider step per quotient
//   bit and loaded into the output register once it is free; saturated or pass-through
//   pixels are popped and loaded into the output register with no divider steps.
// Throughput: reset/measure transactions at one per cycle while the queue has room;
//   map pixels are queued while the queue has room, but the back end works on one job at
//   a time and pops the next one only after loading the last result into the output register.
// Reset: asynchronous active low; statistics return to min = all ones, max = 0.
// ---------------------------------------------------------------------------
// Min/max linear contrast stretch
// Front end tracks min/max and classifies pixels, back end divides or passes on the value.
// ---------------------------------------------------------------------------
`include "min_max_contrast_stretch_macros.svh"

module min_max_contrast_stretch #(
  parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmcs_in_if.sink     in_i,
  mmcs_out_if.source  out_o
);
  import mmcs_pkg::*;

  localparam int ENTRY_BITS = 2 * PIXEL_BITS + KIND_BITS;

  q_stat_t               q_stat;
  logic                  q_push;
  logic                  q_pop;
  logic [ENTRY_BITS-1:0] q_wdata;
  logic [ENTRY_BITS-1:0] q_rdata;

  mmcs_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .entry_o  (q_wdata)
  );

  mmcs_fifo #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  mmcs_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .entry_i  (q_rdata),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

  `MMCS_ASSERT_CLK(a_no_push_full, q_push |-> !q_stat.full, "push into full queue")
  `MMCS_ASSERT_CLK(a_no_pop_empty, q_pop |-> !q_stat.empty, "pop from empty queue")
  `MMCS_ASSERT_CLK(a_map_queued, (in_i.valid && in_i.ready && (in_i.action == ACT_MAP) && q_stat.empty) |=> !q_stat.empty, "map transaction not queued")

endmodule

// ===== hdl/mmcs_front.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch front end
// Accepts transactions, keeps min/max statistics, classifies map pixels
// and queues the work for the back end.
// ---------------------------------------------------------------------------
module mmcs_front #(
  parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  mmcs_in_if.sink                                       in_i,
  input  mmcs_pkg::q_stat_t                             q_stat_i,
  output logic                                          push_o,
  output logic [2*PIXEL_BITS+mmcs_pkg::KIND_BITS-1:0]   entry_o
);
  import mmcs_pkg::*;

  logic [PIXEL_BITS-1:0] low_q, low_d;
  logic [PIXEL_BITS-1:0] high_q, high_d;
  logic                  accept;
  action_e               act;
  logic [PIXEL_BITS-1:0] pix;
  job_kind_e             kind;
  logic [PIXEL_BITS-1:0] opnd;
  logic [PIXEL_BITS-1:0] range;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = action_e'(in_i.action);
  assign pix        = in_i.pixel_in;

  // Classify against the statistics as they stand at acceptance
  always_comb begin
    range = high_q - low_q;
    opnd  = pix;
    if (low_q >= high_q) begin
      kind = JOB_PASS;
    end else if (pix < low_q) begin
      kind = JOB_ZERO;
    end else if (pix > high_q) begin
      kind = JOB_FULL;
    end else begin
      kind = JOB_DIV;
      opnd = pix - low_q;
    end
  end

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    push_o = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_RESET: begin
          low_d  = '1;
          high_d = '0;
        end
        ACT_MEASURE: begin
          if (pix < low_q) low_d = pix;
          if (pix > high_q) high_d = pix;
        end
        ACT_MAP: begin
          push_o = 1'b1;
        end
        default: begin
          // unused code: dropped
        end
      endcase
    end
  end

  assign entry_o = {kind, opnd, range};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '1;
      high_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

endmodule

// ===== hdl/mmcs_fifo.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch job queue
// Small FIFO between front and back end.
// ---------------------------------------------------------------------------
module mmcs_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = mmcs_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  data_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  data_o,
  output mmcs_pkg::q_stat_t stat_o
);
  import mmcs_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] cnt_q;

  function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    if (p == PTR_BITS'(DEPTH - 1)) r = '0;
    else                           r = p + PTR_BITS'(1);
    return r;
  endfunction

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_BITS'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_BITS'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

endmodule

// ===== hdl/mmcs_back.sv =====
// ---------------------------------------------------------------------------
// Contrast stretch back end
// Pops queued jobs, runs a bit-per-cycle restoring divider for the
// scaled offset and holds the result in an output register.
// ---------------------------------------------------------------------------
module mmcs_back #(
  parameter int PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  mmcs_pkg::q_stat_t                             q_stat_i,
  input  logic [2*PIXEL_BITS+mmcs_pkg::KIND_BITS-1:0]   entry_i,
  output logic                                          pop_o,
  mmcs_out_if.source                                    out_o
);
  import mmcs_pkg::*;

  localparam int CNT_BITS = $clog2(PIXEL_BITS + 1);

  back_state_e state_q, state_d;

  job_kind_e               kind;
  logic [PIXEL_BITS-1:0]   opnd;
  logic [PIXEL_BITS-1:0]   range;
  logic [2*PIXEL_BITS-1:0] num;
  logic [PIXEL_BITS-1:0]   direct;

  logic [PIXEL_BITS-1:0] rem_q, lo_q, range_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [PIXEL_BITS:0]   trial;
  logic [PIXEL_BITS:0]   diff;
  logic                  ge;
  logic [PIXEL_BITS:0]   lo_sh;
  logic                  last;

  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_free;

  logic load_div, load_val, step, emit;

  assign kind  = job_kind_e'(entry_i[2*PIXEL_BITS+KIND_BITS-1:2*PIXEL_BITS]);
  assign opnd  = entry_i[2*PIXEL_BITS-1:PIXEL_BITS];
  assign range = entry_i[PIXEL_BITS-1:0];

  // offset * (2^N - 1) as a shift and subtract
  assign num = {opnd, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, opnd};

  always_comb begin
    case (kind)
      JOB_ZERO: direct = '0;
      JOB_FULL: direct = '1;
      default:  direct = opnd;
    endcase
  end

  // One quotient bit per cycle; the upper half of num is below range,
  // so the quotient fits PIXEL_BITS bits.
  assign trial = {rem_q, lo_q[PIXEL_BITS-1]};
  assign diff  = trial - {1'b0, range_q};
  assign ge    = (trial >= {1'b0, range_q});
  assign lo_sh = {lo_q, ge};
  assign last  = (cnt_q == CNT_BITS'(1));

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!q_stat_i.empty) state_d = (kind == JOB_DIV) ? BK_DIV : BK_DONE;
      BK_DIV:  if (last) state_d = BK_DONE;
      BK_DONE: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_div = 1'b0;
    load_val = 1'b0;
    step     = 1'b0;
    emit     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o    = 1'b1;
          load_div = (kind == JOB_DIV);
          load_val = (kind != JOB_DIV);
        end
      end
      BK_DIV:  step = 1'b1;
      BK_DONE: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_div) begin
      rem_q   <= num[2*PIXEL_BITS-1:PIXEL_BITS];
      lo_q    <= num[PIXEL_BITS-1:0];
      range_q <= range;
    end else if (load_val) begin
      lo_q <= direct;
    end else if (step) begin
      rem_q <= ge ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
      lo_q  <= lo_sh[PIXEL_BITS-1:0];
    end
    if (emit) out_pix_q <= lo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_div)  cnt_q <= CNT_BITS'(PIXEL_BITS);
      else if (step) cnt_q <= cnt_q - CNT_BITS'(1);
      if (emit)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = out_pix_q;

endmodule
